// ===== rtl/sorted_timer_queue_top_defines.svh =====
// Assertion macros used by the checker file of the timer queue.
`ifndef SORTED_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_TIMER_QUEUE_TOP_DEFINES_SVH

// Property checked at every rising edge of clk, off while reset is low.
`define STQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on the next edge after the trigger.
`define STQ_ASSERT_NEXT(label, trig, cons, msg) \
	`STQ_ASSERT(label, (trig) |=> (cons), msg)

`endif

// ===== rtl/stq_pkg.sv =====
package stq_pkg;

	localparam int ID_COUNT       = 16;
	localparam int ID_W           = 4;
	localparam int CNT_W          = 5;
	localparam int TAG_W          = 32;
	localparam int PORT_TIME_W    = 32;
	localparam int DEPTH_DEF      = 16;
	localparam int TIME_WIDTH_DEF = 32;
	localparam int IN_DATA_W      = 104;
	localparam int OUT_DATA_W     = 48;
	localparam int OUT_USER_W     = 3;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_ADJUST = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_TICK   = 2'd3
	} stq_req_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_NOT_ACTIVE = 2'd2,
		ST_ACTIVE     = 2'd3
	} stq_status_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_FIND   = 7'b0000100,
		S_WALK   = 7'b0001000,
		S_TCOUNT = 7'b0010000,
		S_TEMIT  = 7'b0100000,
		S_RESP   = 7'b1000000
	} stq_state_t;

	typedef struct packed {
		logic        load;
		logic        pos_clr;
		logic        pos_inc;
		logic        pos_dec;
		logic        set_status;
		stq_status_t status;
		logic        write_entry;
		logic        write_exp;
		logic        remove_pos;
		logic        clr_active;
		logic        insert;
		logic        latch_fcnt;
		logic        pop;
		logic        emit_resp;
	} stq_cmd_t;

	typedef struct packed {
		stq_req_t req;
		logic     id_ok;
		logic     id_active;
		logic     full;
		logic     in_range;
		logic     le_new;
		logic     hit;
		logic     le_now;
		logic     pos_zero;
		logic     pos_one;
		logic     out_free;
	} stq_stat_t;

endpackage

// ===== rtl/stq_datapath.sv =====
module stq_datapath
	import stq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stq_cmd_t              cmd,
	output stq_stat_t             stat,
	input  logic [IN_DATA_W-1:0]  in_tdata,
	input  logic [1:0]            in_tuser,
	output logic                  out_tvalid,
	input  logic                  out_tready,
	output logic [OUT_DATA_W-1:0] out_tdata,
	output logic [OUT_USER_W-1:0] out_tuser,
	output logic                  out_tlast
);

	localparam int SLOTS = (DEPTH < ID_COUNT) ? DEPTH : ID_COUNT;
	localparam int SIW   = $clog2(SLOTS);
	localparam int EXT_W = (TIME_WIDTH > PORT_TIME_W) ? TIME_WIDTH : PORT_TIME_W;

	stq_req_t              req_q;
	logic [ID_W-1:0]       id_q;
	logic [TIME_WIDTH-1:0] exp_q;
	logic [TAG_W-1:0]      tag_q;
	logic [TIME_WIDTH-1:0] now_q;
	stq_status_t           status_q;
	logic [CNT_W-1:0]      pos_q;
	logic [CNT_W-1:0]      held_q;
	logic [CNT_W-1:0]      fcnt_q;
	logic [ID_COUNT-1:0]   act_q;
	logic [ID_W-1:0]       slot_q [SLOTS];
	logic [TIME_WIDTH-1:0] exp_mem_q [ID_COUNT];
	logic [TAG_W-1:0]      tag_mem_q [ID_COUNT];

	logic                  ovalid_q;
	stq_status_t           ostatus_q;
	logic                  ofired_q;
	logic [ID_W-1:0]       oid_q;
	logic [TAG_W-1:0]      otag_q;
	logic                  olast_q;
	logic [CNT_W-1:0]      ocnt_q;

	logic [EXT_W-1:0]      exp_ext;
	logic [EXT_W-1:0]      now_ext;
	logic [ID_W-1:0]       cur_id;
	logic [TIME_WIDTH-1:0] cur_exp;
	logic [ID_W-1:0]       head_id;
	logic [CNT_W-1:0]      rpos;

	assign exp_ext = EXT_W'(in_tdata[35:4]);
	assign now_ext = EXT_W'(in_tdata[99:68]);
	assign cur_id  = slot_q[pos_q[SIW-1:0]];
	assign cur_exp = exp_mem_q[cur_id];
	assign head_id = slot_q[0];
	assign rpos    = cmd.pop ? '0 : pos_q;

	always_comb begin
		stat.req       = req_q;
		stat.id_ok     = {1'b0, id_q} < CNT_W'(SLOTS);
		stat.id_active = act_q[id_q];
		stat.full      = held_q >= CNT_W'(SLOTS);
		stat.in_range  = pos_q < held_q;
		stat.le_new    = cur_exp <= exp_q;
		stat.hit       = cur_id == id_q;
		stat.le_now    = cur_exp <= now_q;
		stat.pos_zero  = pos_q == '0;
		stat.pos_one   = pos_q == CNT_W'(1);
		stat.out_free  = !ovalid_q || out_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			held_q   <= '0;
			act_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.pos_clr) begin
				pos_q <= '0;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_q + CNT_W'(1);
			end else if (cmd.pos_dec) begin
				pos_q <= pos_q - CNT_W'(1);
			end
			if (cmd.insert) begin
				held_q <= held_q + CNT_W'(1);
			end else if (cmd.remove_pos || cmd.pop) begin
				held_q <= held_q - CNT_W'(1);
			end
			if (cmd.write_entry) begin
				act_q[id_q] <= 1'b1;
			end else if (cmd.clr_active) begin
				act_q[id_q] <= 1'b0;
			end else if (cmd.pop) begin
				act_q[head_id] <= 1'b0;
			end
			if (cmd.emit_resp || cmd.pop) begin
				ovalid_q <= 1'b1;
			end else if (out_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= stq_req_t'(in_tuser);
			id_q  <= in_tdata[3:0];
			exp_q <= exp_ext[TIME_WIDTH-1:0];
			tag_q <= in_tdata[67:36];
			now_q <= now_ext[TIME_WIDTH-1:0];
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.latch_fcnt) begin
			fcnt_q <= held_q - pos_q;
		end
		if (cmd.write_entry || cmd.write_exp) begin
			exp_mem_q[id_q] <= exp_q;
		end
		if (cmd.write_entry) begin
			tag_mem_q[id_q] <= tag_q;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (cmd.insert) begin
				if (CNT_W'(i) == pos_q) begin
					slot_q[i] <= id_q;
				end else if (CNT_W'(i) > pos_q) begin
					slot_q[i] <= slot_q[(i == 0) ? 0 : i - 1];
				end
			end else if (cmd.remove_pos || cmd.pop) begin
				if (CNT_W'(i) >= rpos && i < SLOTS - 1) begin
					slot_q[i] <= slot_q[(i == SLOTS - 1) ? i : i + 1];
				end
			end
		end
		if (cmd.pop) begin
			ostatus_q <= ST_OK;
			ofired_q  <= 1'b1;
			oid_q     <= head_id;
			otag_q    <= tag_mem_q[head_id];
			olast_q   <= pos_q == CNT_W'(1);
			ocnt_q    <= fcnt_q;
		end else if (cmd.emit_resp) begin
			ostatus_q <= status_q;
			ofired_q  <= 1'b0;
			oid_q     <= '0;
			otag_q    <= '0;
			olast_q   <= 1'b1;
			ocnt_q    <= held_q;
		end
	end

	assign out_tvalid = ovalid_q;
	assign out_tdata  = {{(OUT_DATA_W - CNT_W - TAG_W - ID_W){1'b0}}, ocnt_q, otag_q, oid_q};
	assign out_tuser  = {ofired_q, ostatus_q};
	assign out_tlast  = olast_q;

endmodule

// ===== rtl/stq_ctrl.sv =====
module stq_ctrl
	import stq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  stq_stat_t stat,
	output stq_cmd_t  cmd
);

	stq_state_t state_q;
	stq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.set_status = 1'b1;
				cmd.status     = ST_OK;
				cmd.pos_clr    = 1'b1;
				case (stat.req)
					REQ_ADD: begin
						if (!stat.id_ok || (stat.full && !stat.id_active)) begin
							cmd.status = ST_FULL;
							state_d    = S_RESP;
						end else if (stat.id_active) begin
							cmd.status = ST_ACTIVE;
							state_d    = S_RESP;
						end else begin
							cmd.write_entry = 1'b1;
							state_d         = S_WALK;
						end
					end
					REQ_ADJUST, REQ_DELETE: begin
						if (!stat.id_ok || !stat.id_active) begin
							cmd.status = ST_NOT_ACTIVE;
							state_d    = S_RESP;
						end else begin
							state_d = S_FIND;
						end
					end
					default: begin
						state_d = S_TCOUNT;
					end
				endcase
			end
			S_FIND: begin
				if (stat.hit) begin
					cmd.remove_pos = 1'b1;
					if (stat.req == REQ_DELETE) begin
						cmd.clr_active = 1'b1;
						state_d        = S_RESP;
					end else begin
						cmd.write_exp = 1'b1;
						cmd.pos_clr   = 1'b1;
						state_d       = S_WALK;
					end
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			S_WALK: begin
				if (stat.in_range && stat.le_new) begin
					cmd.pos_inc = 1'b1;
				end else begin
					cmd.insert = 1'b1;
					state_d    = S_RESP;
				end
			end
			S_TCOUNT: begin
				if (stat.in_range && stat.le_now) begin
					cmd.pos_inc = 1'b1;
				end else if (stat.pos_zero) begin
					state_d = S_RESP;
				end else begin
					cmd.latch_fcnt = 1'b1;
					state_d        = S_TEMIT;
				end
			end
			S_TEMIT: begin
				if (stat.out_free) begin
					cmd.pop     = 1'b1;
					cmd.pos_dec = 1'b1;
					if (stat.pos_one) begin
						state_d = S_IDLE;
					end
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.emit_resp = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/sorted_timer_queue_top.sv =====
// An add walks the slot row to its place; an adjust searches for the handle, then walks;
// a delete searches and removes. A tick counts its expired timers before its first result,
// then gives one expired timer per cycle while the output is taken.
// Requests are taken one at a time: a new one is accepted only once the controller is
// back in idle.
// Reset (arst_n low, asynchronous): no timers held, output empty, controller idle.
module sorted_timer_queue_top
	import stq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// timer_id[3:0], expiry_time[35:4], user_tag[67:36], current_time[99:68], zeros above
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// req_type[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// fired_id[3:0], fired_tag[35:4], active_count[40:36], zeros above
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status[1:0], fired[2]
	output logic [OUT_USER_W-1:0] m_tuser,
	output logic                  m_tlast
);

	// The controller sequences each request through check, search, walk, count
	// and emit steps. The datapath keeps the handles in expiry order in a slot
	// row and shifts the slots past an insert or a removal by one place, while
	// the pointer steps through the row one slot per cycle comparing expiries.
	stq_cmd_t  cmd;
	stq_stat_t stat;

	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The result register lets the last beat wait for the sink while the
	// controller returns to idle and takes the next request.
	stq_datapath #(
		.DEPTH      (DEPTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_tdata   (s_tdata),
		.in_tuser   (s_tuser),
		.out_tvalid (m_tvalid),
		.out_tready (m_tready),
		.out_tdata  (m_tdata),
		.out_tuser  (m_tuser),
		.out_tlast  (m_tlast)
	);

endmodule

// ===== rtl/stq_checker.sv =====
`include "sorted_timer_queue_top_defines.svh"

module stq_checker
	import stq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser,
	input logic                  m_tlast
);

	`STQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
	`STQ_ASSERT(a_count_range, m_tvalid |-> m_tdata[40:36] <= 5'd16, "active count beyond table size")
	`STQ_ASSERT(a_fired_ok, m_tvalid && m_tuser[2] |-> m_tuser[1:0] == 2'd0, "expired timer with error status")
	`STQ_ASSERT(a_plain_last, m_tvalid && !m_tuser[2] |-> m_tlast && m_tdata[35:0] == 36'd0, "status beat not final or not clean")

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (.*);

// ===== dv/tb_sorted_timer_queue_top.sv =====
module tb_sorted_timer_queue_top;
	import stq_pkg::*;

	// One expected output beat of the timer queue.
	typedef struct {
		stq_status_t status;
		logic        fired;
		logic [3:0]  fired_id;
		logic [31:0] fired_tag;
		logic        last;
		logic [4:0]  active_count;
	} beat_t;

	// One row of the directed table. When check_now is set on a non-tick row, or in
	// the first row, the typed status and count are compared with the predictor's.
	typedef struct {
		stq_req_t    req;
		logic [3:0]  id;
		logic [31:0] expiry;
		logic [31:0] tag;
		logic [31:0] now;
		logic        check_now;
		stq_status_t want_status;
		logic [4:0]  want_count;
	} row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic m_tlast;

	sorted_timer_queue_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Shadow copy of the timer table: handles in expiry order plus per-handle data.
	logic [3:0]  sh_order[16];
	logic [31:0] sh_expiry[16];
	logic [31:0] sh_tag[16];
	logic        sh_active[16];
	int          sh_held;

	beat_t pending_beats[$];
	int    mismatches;
	int    beats_seen;
	int    fired_seen;
	int    sender_idle_pct;
	int    receiver_stall_pct;
	longint cycle_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Runaway guard: far above the slowest correct run of this stimulus.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("tb_sorted_timer_queue_top failed");
				$finish;
			end
		end
	end

	function automatic void unlink_handle(input logic [3:0] id);
		int pos;
		pos = -1;
		for (int i = 0; i < sh_held; i++)
			if (pos < 0 && sh_order[i] == id) pos = i;
		if (pos < 0) return;
		for (int i = pos; i + 1 < sh_held; i++) sh_order[i] = sh_order[i + 1];
		sh_held--;
	endfunction

	// Insert behind every timer whose expiry is not later, so ties keep arrival order.
	function automatic void link_handle(input logic [3:0] id);
		int pos;
		pos = 0;
		while (pos < sh_held && sh_expiry[sh_order[pos]] <= sh_expiry[id]) pos++;
		for (int i = sh_held; i > pos; i--) sh_order[i] = sh_order[i - 1];
		sh_order[pos] = id;
		sh_held++;
	endfunction

	// Applies one request to the shadow table and queues the beats it should produce.
	function automatic void predict_request(input stq_req_t req, input logic [3:0] id,
			input logic [31:0] expiry, input logic [31:0] tag, input logic [31:0] now);
		beat_t b;
		logic [3:0] fired_ids[$];
		stq_status_t st;
		st = ST_OK;
		if (req == REQ_TICK) begin
			while (sh_held > 0 && now >= sh_expiry[sh_order[0]]) begin
				fired_ids.push_back(sh_order[0]);
				sh_active[sh_order[0]] = 1'b0;
				unlink_handle(sh_order[0]);
			end
			if (fired_ids.size() == 0) begin
				b = '{ST_OK, 1'b0, 4'd0, 32'd0, 1'b1, 5'(sh_held)};
				pending_beats.push_back(b);
			end else begin
				foreach (fired_ids[k]) begin
					b = '{ST_OK, 1'b1, fired_ids[k], sh_tag[fired_ids[k]],
						k == fired_ids.size() - 1, 5'(sh_held)};
					pending_beats.push_back(b);
				end
			end
			return;
		end
		if (req == REQ_ADD) begin
			if (sh_active[id]) st = ST_ACTIVE;
			else if (sh_held >= 16) st = ST_FULL;
			else begin
				sh_expiry[id] = expiry;
				sh_tag[id] = tag;
				sh_active[id] = 1'b1;
				link_handle(id);
			end
		end else if (!sh_active[id]) begin
			st = ST_NOT_ACTIVE;
		end else if (req == REQ_ADJUST) begin
			unlink_handle(id);
			sh_expiry[id] = expiry;
			link_handle(id);
		end else begin
			unlink_handle(id);
			sh_active[id] = 1'b0;
		end
		b = '{st, 1'b0, 4'd0, 32'd0, 1'b1, 5'(sh_held)};
		pending_beats.push_back(b);
	endfunction

	// Sends one request beat, holding it until the block takes it. Valid stays high
	// afterwards so back to back requests need no gap; idling or draining drops it.
	task automatic send_request(input stq_req_t req, input logic [3:0] id,
			input logic [31:0] expiry, input logic [31:0] tag, input logic [31:0] now);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {4'd0, now, tag, expiry, id};
		predict_request(req, id, expiry, tag, now);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Receiver: random backpressure; each taken beat is checked against the oldest one due.
	always @(posedge clk) begin
		beat_t w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				beats_seen++;
				if (m_tuser[2]) fired_seen++;
				if (pending_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected beat data=%h user=%h", m_tdata, m_tuser);
				end else begin
					w = pending_beats.pop_front();
					if (m_tuser[1:0] != w.status || m_tuser[2] != w.fired
							|| m_tdata[3:0] != w.fired_id || m_tdata[35:4] != w.fired_tag
							|| m_tlast != w.last || m_tdata[40:36] != w.active_count) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: want st=%0d f=%0b id=%0d tag=%h last=%0b cnt=%0d",
								w.status, w.fired, w.fired_id, w.fired_tag, w.last,
								w.active_count);
							$display("          got  st=%0d f=%0b id=%0d tag=%h last=%0b cnt=%0d",
								m_tuser[1:0], m_tuser[2], m_tdata[3:0], m_tdata[35:4], m_tlast,
								m_tdata[40:36]);
						end
					end
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	row_t directed[$];
	int row_base;
	stq_req_t rq;
	logic [3:0] rid;
	logic [31:0] rnow;
	logic [31:0] rexp;

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		mismatches = 0;
		beats_seen = 0;
		fired_seen = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		rnow = '0;
		sh_held = 0;
		for (int i = 0; i < 16; i++) begin
			sh_order[i] = '0; sh_expiry[i] = '0; sh_tag[i] = '0; sh_active[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table errors, extremes, ties, adjust both ways, full table.
		directed.push_back('{REQ_TICK, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1, ST_OK, 5'd0});
		directed.push_back('{REQ_DELETE, 4'd5, 32'd0, 32'd0, 32'd0, 1, ST_NOT_ACTIVE, 5'd0});
		directed.push_back('{REQ_ADJUST, 4'd15, 32'd9, 32'd0, 32'd0, 1, ST_NOT_ACTIVE, 5'd0});
		directed.push_back('{REQ_ADD, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1, ST_OK, 5'd1});
		directed.push_back('{REQ_ADD, 4'd15, 32'd0, 32'h0, 32'hFFFF_FFFF, 1, ST_OK, 5'd2});
		directed.push_back('{REQ_ADD, 4'd0, 32'd5, 32'd1, 32'd0, 1, ST_ACTIVE, 5'd2});
		directed.push_back('{REQ_ADD, 4'd3, 32'd100, 32'hA5A5_5A5A, 32'd0, 0, ST_OK, 5'd0});
		directed.push_back('{REQ_ADD, 4'd4, 32'd100, 32'h5A5A_A5A5, 32'd0, 0, ST_OK, 5'd0});
		directed.push_back('{REQ_ADJUST, 4'd0, 32'd50, 32'd0, 32'd0, 0, ST_OK, 5'd0});
		directed.push_back('{REQ_ADJUST, 4'd15, 32'd200, 32'd0, 32'd0, 0, ST_OK, 5'd0});
		directed.push_back('{REQ_TICK, 4'd0, 32'd0, 32'd0, 32'd99, 0, ST_OK, 5'd0});
		directed.push_back('{REQ_TICK, 4'd0, 32'd0, 32'd0, 32'd100, 0, ST_OK, 5'd0});
		directed.push_back('{REQ_DELETE, 4'd15, 32'd0, 32'd0, 32'd0, 1, ST_OK, 5'd0});
		for (int i = 0; i < 16; i++)
			directed.push_back('{REQ_ADD, 4'(i), 32'(1000 - i / 2), 32'(i * 7), 32'd0, 0, ST_OK, 5'd0});
		directed.push_back('{REQ_TICK, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1, ST_OK, 5'd0});
		// The last tick drains all sixteen, so only its final beat matches the typed row;
		// non-tick rows with check_now, and the first row, compare the typed status/count with the predictor's last beat.
		foreach (directed[r]) begin
			row_base = pending_beats.size();
			send_request(directed[r].req, directed[r].id, directed[r].expiry,
				directed[r].tag, directed[r].now);
			if (directed[r].check_now && directed[r].req != REQ_TICK || r == 0)
				if (pending_beats[$].status != directed[r].want_status
						|| pending_beats[$].active_count != directed[r].want_count) begin
					mismatches++;
					$display("table row %0d disagrees with prediction", r);
				end
		end
		wait_drained();

		// Random phases with different idling; valid handles, mostly on a small time window
		// so timers accumulate, tie and expire, with some wide random noise mixed in.
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = (ph == 1) ? 66 : (ph == 3) ? 38 : 0;
			receiver_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 38 : 0;
			for (int n = 0; n < 32; n++) begin
				rq = stq_req_t'($urandom_range(9) < 5 ? REQ_ADD : $urandom_range(3));
				rid = 4'($urandom_range(15));
				rexp = ($urandom_range(9) == 0) ? $urandom() : rnow + $urandom_range(60);
				if (rq == REQ_TICK)
					rnow = ($urandom_range(19) == 0) ? $urandom() : rnow + $urandom_range(30);
				send_request(rq, rid, rexp, $urandom(), rnow);
				if (ph == 1 && n == 20) wait_drained();
			end
			wait_drained();
		end
		send_request(REQ_TICK, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
		wait_drained();

		$display("Covered %0d output beats, %0d of them expired timers, across four idling phases.",
			beats_seen, fired_seen);
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("tb_sorted_timer_queue_top passed");
		end else begin
			$display("tb_sorted_timer_queue_top failed");
		end
		$finish;
	end

endmodule
